@@ rtl/flash_sector_write_planner_defines.svh @@
// Assertion macros used by the back end of the flash sector write planner.
`ifndef FLASH_SECTOR_WRITE_PLANNER_DEFINES_SVH
`define FLASH_SECTOR_WRITE_PLANNER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define FSWP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define FSWP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fswp_pkg.sv @@
// Package with the types and constants of the flash sector write planner.
`timescale 1ns / 1ps
package fswp_pkg;

    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int JOB_ADDR_W       = 32;
    localparam int JOB_LEN_W        = 17;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_OLD   = 2'd1,
        CMD_NEW   = 2'd2,
        CMD_FETCH = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_ERASE = 3'd1,
        OP_PROG  = 3'd2,
        OP_DONE  = 3'd3,
        OP_FETCH = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FILL  = 2'd1,
        PH_MERGE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        JOB_FETCH = 2'd0,
        JOB_DONE  = 2'd1,
        JOB_READ  = 2'd2,
        JOB_PLAN  = 2'd3
    } t_job_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DONE,
        ST_READ,
        ST_ERASE,
        ST_PROG
    } t_bstate;

    typedef struct packed {
        t_job_kind             kind;
        logic                  erase;
        logic                  tail_read;
        logic [JOB_ADDR_W-1:0] base;
        logic [JOB_ADDR_W-1:0] addr;
        logic [JOB_LEN_W-1:0]  len;
        logic [JOB_ADDR_W-1:0] next;
        logic [7:0]            data;
    } t_job;

endpackage

@@ rtl/flash_sector_write_planner.sv @@
// Top level of the flash sector write planner.
// Usage: an item (cmd, start_address, length, data_byte, fetch_index) is transferred at a
// rising edge where start is high and busy is low. A start item opens a write; the block
// then asks for a sector read, takes the whole old sector as old-byte items, then the
// span's new bytes as new-data items, and answers with an erase (when the span held
// programmed bytes) and page programs, followed by the next sector read or done.
// Fetch items return buffer bytes, for example the data of each program.
// Results appear on the o_ ports for one cycle each with o_valid high; o_last marks the
// final result of an item. The receiver cannot stall, so results are never held.
// An item's job passes from the front-end job register through the job queue to the
// sequencer, whose results are registered. The front end takes one item per cycle while
// busy is low; the sequencer pops a job only when idle, so busy rises once the queued jobs
// plus the one entering fill the four-entry queue. Old bytes (no result) and new bytes stream alike.
// Synchronous reset returns to idle with an empty queue; the sector buffer is not
// cleared and holds undefined data until written.
`timescale 1ns / 1ps
module flash_sector_write_planner #(
    parameter int SECTOR_BYTES = fswp_pkg::SECTOR_BYTES_DEF,
    parameter int PAGE_BYTES   = fswp_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS    = fswp_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [23:0] i_start_address,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_fetch_index,
    output logic        o_valid,
    output logic [2:0]  o_op,
    output logic [23:0] o_flash_address,
    output logic [12:0] o_byte_count,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import fswp_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic           accept;
    logic           push;
    logic           pending;
    t_job           front_job;
    t_job           queue_job;
    logic [$bits(t_job)-1:0] queue_data;
    logic           pop;
    logic           empty;
    logic [QCW-1:0] count;
    logic [QCW:0]   occupancy;

    assign occupancy = (QCW + 1)'(count) + (QCW + 1)'(pending);
    assign busy      = occupancy >= (QCW + 1)'(QUEUE_DEPTH);
    assign accept    = start && !busy;
    assign queue_job = t_job'(queue_data);

    fswp_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_cmd           (i_cmd),
        .i_start_address (i_start_address),
        .i_length        (i_length),
        .i_data_byte     (i_data_byte),
        .i_fetch_index   (i_fetch_index),
        .o_push          (push),
        .o_pending       (pending),
        .o_job           (front_job)
    );

    fswp_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (queue_data),
        .o_empty (empty),
        .o_count (count)
    );

    fswp_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_job           (queue_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_op            (o_op),
        .o_flash_address (o_flash_address),
        .o_byte_count    (o_byte_count),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last)
    );
endmodule

@@ rtl/fswp_ram.sv @@
// Generic single-clock RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module fswp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/fswp_front.sv @@
// Front end: takes items, tracks the sector phases, keeps the buffer and issues jobs.
`timescale 1ns / 1ps
module fswp_front #(
    parameter int SECTOR_BYTES = fswp_pkg::SECTOR_BYTES_DEF,
    parameter int ADDR_BITS    = fswp_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_cmd,
    input  logic [23:0]    i_start_address,
    input  logic [15:0]    i_length,
    input  logic [7:0]     i_data_byte,
    input  logic [11:0]    i_fetch_index,
    output logic           o_push,
    output logic           o_pending,
    output fswp_pkg::t_job o_job
);
    import fswp_pkg::*;

    localparam int SB = $clog2(SECTOR_BYTES);
    localparam int LW = SB + 1;
    localparam int AW = ADDR_BITS;
    localparam int RW = 17;
    localparam logic [AW-1:0] OFF_MASK = AW'(SECTOR_BYTES - 1);

    t_phase        r_phase, n_phase;
    logic [AW-1:0] r_cur, n_cur;
    logic [15:0]   r_left, n_left;
    logic [SB-1:0] r_off, n_off;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_end, n_end;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_merge, n_merge;
    logic          r_erase, n_erase;
    logic          r_s1_valid;
    logic          r_s1_oob;
    t_job          r_s1_job;

    t_job          job;
    logic          job_valid;
    logic          wr_en;
    logic [SB-1:0] wr_addr;
    logic [SB-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          oob;
    logic [AW-1:0] c2;
    logic [15:0]   l2;
    logic [AW-1:0] c_sel;
    logic [15:0]   l_sel;
    logic [SB-1:0] sp_off;
    logic [RW-1:0] sp_room;
    logic [LW-1:0] sp_len;
    t_cmd          cmd;

    fswp_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cmd     = t_cmd'(i_cmd);
    assign rd_addr = SB'(i_fetch_index);
    assign oob     = 32'(i_fetch_index) >= 32'(SECTOR_BYTES);
    assign c2      = r_cur + AW'(r_len);
    assign l2      = r_left - 16'(r_len);
    assign c_sel   = (cmd == CMD_START) ? AW'(i_start_address) : c2;
    assign l_sel   = (cmd == CMD_START) ? i_length : l2;
    assign sp_off  = SB'(c_sel);
    assign sp_room = RW'(SECTOR_BYTES) - RW'(sp_off);
    assign sp_len  = (RW'(l_sel) < sp_room) ? LW'(l_sel) : LW'(sp_room);

    always_comb begin
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_left    = r_left;
        n_off     = r_off;
        n_len     = r_len;
        n_end     = r_end;
        n_fill    = r_fill;
        n_merge   = r_merge;
        n_erase   = r_erase;
        job       = '0;
        job_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_fill[SB-1:0];
        if (i_accept) begin
            unique case (cmd)
                CMD_FETCH: begin
                    job.kind  = JOB_FETCH;
                    job_valid = 1'b1;
                end
                CMD_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_cur     = c_sel;
                        n_left    = l_sel;
                        job_valid = 1'b1;
                        if (l_sel == 16'd0) begin
                            job.kind = JOB_DONE;
                        end else begin
                            n_off    = sp_off;
                            n_len    = sp_len;
                            n_end    = LW'(sp_off) + sp_len;
                            n_fill   = '0;
                            n_merge  = '0;
                            n_erase  = 1'b0;
                            n_phase  = PH_FILL;
                            job.kind = JOB_READ;
                            job.base = JOB_ADDR_W'(c_sel & ~OFF_MASK);
                        end
                    end
                end
                CMD_OLD: begin
                    if (r_phase == PH_FILL) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + 1'b1;
                        if (r_fill >= LW'(r_off) && r_fill < r_end
                                && i_data_byte != ERASED_BYTE) begin
                            n_erase = 1'b1;
                        end
                        if (r_fill == LW'(SECTOR_BYTES - 1)) begin
                            n_phase = PH_MERGE;
                        end
                    end
                end
                CMD_NEW: begin
                    if (r_phase == PH_MERGE) begin
                        wr_en   = 1'b1;
                        wr_addr = r_off + r_merge[SB-1:0];
                        n_merge = r_merge + 1'b1;
                        if (n_merge == r_len) begin
                            job_valid     = 1'b1;
                            job.kind      = JOB_PLAN;
                            job.erase     = r_erase;
                            job.base      = JOB_ADDR_W'(r_cur & ~OFF_MASK);
                            job.addr      = JOB_ADDR_W'(r_cur);
                            job.len       = JOB_LEN_W'(r_len);
                            job.next      = JOB_ADDR_W'(c2 & ~OFF_MASK);
                            job.tail_read = (l2 != 16'd0);
                            n_cur         = c2;
                            n_left        = l2;
                            if (l2 == 16'd0) begin
                                n_phase = PH_IDLE;
                                n_off   = '0;
                                n_len   = '0;
                                n_end   = '0;
                                n_fill  = '0;
                                n_merge = '0;
                                n_erase = 1'b0;
                            end else begin
                                n_off   = sp_off;
                                n_len   = sp_len;
                                n_end   = LW'(sp_off) + sp_len;
                                n_fill  = '0;
                                n_merge = '0;
                                n_erase = 1'b0;
                                n_phase = PH_FILL;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cur      <= '0;
            r_left     <= '0;
            r_off      <= '0;
            r_len      <= '0;
            r_end      <= '0;
            r_fill     <= '0;
            r_merge    <= '0;
            r_erase    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cur      <= n_cur;
            r_left     <= n_left;
            r_off      <= n_off;
            r_len      <= n_len;
            r_end      <= n_end;
            r_fill     <= n_fill;
            r_merge    <= n_merge;
            r_erase    <= n_erase;
            r_s1_valid <= job_valid;
        end
        r_s1_job <= job;
        r_s1_oob <= oob;
    end

    always_comb begin
        o_job = r_s1_job;
        if (r_s1_job.kind == JOB_FETCH) begin
            o_job.data = r_s1_oob ? 8'd0 : rd_data;
        end
    end

    assign o_push    = r_s1_valid;
    assign o_pending = r_s1_valid;
endmodule

@@ rtl/fswp_queue.sv @@
// Short job queue between the front end and the operation sequencer.
`timescale 1ns / 1ps
module fswp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
endmodule

@@ rtl/fswp_back.sv @@
// Back end: expands queued jobs into read, erase, program, done and fetch results.
`timescale 1ns / 1ps
module fswp_back #(
    parameter int SECTOR_BYTES = fswp_pkg::SECTOR_BYTES_DEF,
    parameter int PAGE_BYTES   = fswp_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS    = fswp_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fswp_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    output logic [2:0]     o_op,
    output logic [23:0]    o_flash_address,
    output logic [12:0]    o_byte_count,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);
    import fswp_pkg::*;
    `include "flash_sector_write_planner_defines.svh"

    localparam int SB = $clog2(SECTOR_BYTES);
    localparam int LW = SB + 1;
    localparam int PB = $clog2(PAGE_BYTES);
    localparam int AW = ADDR_BITS;
    localparam int CW = (PB + 1 > LW) ? PB + 1 : LW;

    t_bstate       r_state, n_state;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [LW-1:0] r_n, n_n;
    logic [AW-1:0] r_next, n_next;
    logic [7:0]    r_byte, n_byte;
    logic          r_tail_read, n_tail_read;

    logic          r_valid, n_valid;
    t_op           r_op, n_op;
    logic [23:0]   r_addr, n_addr;
    logic [12:0]   r_count, n_count;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_last, n_last;

    logic [PB:0]   room;
    logic [CW-1:0] chunk;

    assign room  = (PB + 1)'(PAGE_BYTES) - (PB + 1)'(r_paddr[PB-1:0]);
    assign chunk = (CW'(r_n) < CW'(room)) ? CW'(r_n) : CW'(room);

    always_comb begin
        n_state     = r_state;
        n_paddr     = r_paddr;
        n_n         = r_n;
        n_next      = r_next;
        n_byte      = r_byte;
        n_tail_read = r_tail_read;
        n_valid     = 1'b0;
        n_op        = OP_DONE;
        n_addr      = '0;
        n_count     = '0;
        n_obyte     = '0;
        n_last      = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        JOB_FETCH: begin
                            n_byte  = i_job.data;
                            n_state = ST_FETCH;
                        end
                        JOB_DONE: begin
                            n_state = ST_DONE;
                        end
                        JOB_READ: begin
                            n_next  = AW'(i_job.base);
                            n_state = ST_READ;
                        end
                        JOB_PLAN: begin
                            n_tail_read = i_job.tail_read;
                            n_next      = AW'(i_job.next);
                            if (i_job.erase) begin
                                n_paddr = AW'(i_job.base);
                                n_n     = LW'(SECTOR_BYTES);
                                n_state = ST_ERASE;
                            end else begin
                                n_paddr = AW'(i_job.addr);
                                n_n     = LW'(i_job.len);
                                n_state = ST_PROG;
                            end
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_valid = 1'b1;
                n_op    = OP_FETCH;
                n_obyte = r_byte;
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_op    = OP_DONE;
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_READ: begin
                n_valid = 1'b1;
                n_op    = OP_READ;
                n_addr  = 24'(r_next);
                n_count = 13'(SECTOR_BYTES);
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_ERASE: begin
                n_valid = 1'b1;
                n_op    = OP_ERASE;
                n_addr  = 24'(r_paddr);
                n_state = ST_PROG;
            end
            ST_PROG: begin
                n_valid = 1'b1;
                n_op    = OP_PROG;
                n_addr  = 24'(r_paddr);
                n_count = 13'(chunk);
                n_paddr = r_paddr + AW'(chunk);
                n_n     = r_n - LW'(chunk);
                if (CW'(r_n) <= CW'(room)) begin
                    n_state = r_tail_read ? ST_READ : ST_DONE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_paddr     <= n_paddr;
        r_n         <= n_n;
        r_next      <= n_next;
        r_byte      <= n_byte;
        r_tail_read <= n_tail_read;
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_count     <= n_count;
        r_obyte     <= n_obyte;
        r_last      <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_op            = r_op;
    assign o_flash_address = r_addr;
    assign o_byte_count    = r_count;
    assign o_out_byte      = r_obyte;
    assign o_last          = r_last;

    `FSWP_ASSERT_IMP(a_prog_has_bytes, r_state == ST_PROG, r_n != '0, "Program with no bytes left")
    `FSWP_ASSERT_NXT(a_erase_then_prog, r_state == ST_ERASE, r_state == ST_PROG, "Erase not followed by programs")
    `FSWP_ASSERT_IMP(a_last_ends_job, r_valid && r_last, r_state == ST_IDLE, "Job still running after its last result")
endmodule

@@ tb/flash_sector_write_planner_tb.sv @@
// Self-checking testbench of the flash sector write planner with a predicting scoreboard.
`timescale 1ns / 1ps
module flash_sector_write_planner_tb;
    import fswp_pkg::*;

    localparam int SECTOR = 4096;
    localparam int PAGE = 256;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        t_op         op;
        logic [23:0] addr;
        logic [12:0] count;
        logic [7:0]  data;
        logic        last;
    } t_flash_op;

    class write_plan_predictor;
        t_flash_op   planned_ops[$];
        logic [7:0]  buffer[SECTOR];
        bit          written[SECTOR];
        logic [23:0] cur_addr;
        logic [16:0] remaining;
        logic [11:0] span_off;
        logic [12:0] span_len;
        logic [12:0] filled;
        logic [12:0] merged;
        bit          dirty;
        t_phase      phase;
        int          mismatches;
        int          checked;

        function new();
            cur_addr = '0;
            remaining = '0;
            span_off = '0;
            span_len = '0;
            filled = '0;
            merged = '0;
            dirty = 0;
            phase = PH_IDLE;
            mismatches = 0;
            checked = 0;
        endfunction

        function void plan(t_op op, logic [23:0] addr, logic [12:0] count, logic [7:0] data);
            t_flash_op r;
            r.op = op;
            r.addr = addr;
            r.count = count;
            r.data = data;
            r.last = 0;
            planned_ops.push_back(r);
        endfunction

        function void open_span();
            int room;
            span_off = cur_addr[11:0];
            room = SECTOR - span_off;
            span_len = (remaining < room) ? remaining : room;
            filled = '0;
            merged = '0;
            dirty = 0;
            phase = PH_FILL;
            plan(OP_READ, cur_addr - span_off, 13'(SECTOR), '0);
        endfunction

        function void plan_pages(logic [23:0] addr, int n);
            int room;
            int c;
            while (n > 0) begin
                room = PAGE - (addr % PAGE);
                c = (n < room) ? n : room;
                plan(OP_PROG, addr, 13'(c), '0);
                addr = addr + 24'(c);
                n -= c;
            end
        endfunction

        function void note_transfer(t_cmd cmd, logic [23:0] addr, logic [15:0] len,
                                    logic [7:0] data, logic [11:0] idx);
            int before_n;
            logic [23:0] base;
            before_n = planned_ops.size();
            case (cmd)
                CMD_FETCH: begin
                    plan(OP_FETCH, '0, '0, buffer[idx]);
                end
                CMD_START: begin
                    if (phase == PH_IDLE) begin
                        cur_addr = addr;
                        remaining = len;
                        if (len == 0) plan(OP_DONE, '0, '0, '0);
                        else open_span();
                    end
                end
                CMD_OLD: begin
                    if (phase == PH_FILL) begin
                        buffer[filled[11:0]] = data;
                        written[filled[11:0]] = 1;
                        if (filled >= span_off && filled < span_off + span_len
                            && data != ERASED_BYTE) dirty = 1;
                        filled++;
                        if (filled >= SECTOR) phase = PH_MERGE;
                    end
                end
                default: begin
                    if (phase == PH_MERGE) begin
                        buffer[12'(span_off + merged)] = data;
                        merged++;
                        if (merged >= span_len) begin
                            base = cur_addr - span_off;
                            if (dirty) begin
                                plan(OP_ERASE, base, '0, '0);
                                plan_pages(base, SECTOR);
                            end else begin
                                plan_pages(cur_addr, span_len);
                            end
                            cur_addr = cur_addr + span_len;
                            remaining = remaining - span_len;
                            if (remaining == 0) begin
                                phase = PH_IDLE;
                                span_off = '0;
                                span_len = '0;
                                filled = '0;
                                merged = '0;
                                dirty = 0;
                                plan(OP_DONE, '0, '0, '0);
                            end else begin
                                open_span();
                            end
                        end
                    end
                end
            endcase
            if (planned_ops.size() > before_n) planned_ops[planned_ops.size() - 1].last = 1;
        endfunction

        function void check_result(logic [2:0] op, logic [23:0] addr, logic [12:0] count,
                                   logic [7:0] data, logic last);
            t_flash_op e;
            checked++;
            if (planned_ops.size() == 0) begin
                $error("unexpected result: op %0d address %h", op, addr);
                mismatches++;
                return;
            end
            e = planned_ops.pop_front();
            if (op !== e.op) begin
                $error("op: expected %0d, actual %0d", e.op, op);
                mismatches++;
            end
            if (addr !== e.addr) begin
                $error("flash_address: expected %h, actual %h", e.addr, addr);
                mismatches++;
            end
            if (count !== e.count) begin
                $error("byte_count: expected %0d, actual %0d", e.count, count);
                mismatches++;
            end
            if (data !== e.data) begin
                $error("out_byte: expected %h, actual %h", e.data, data);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [23:0] i_start_address = '0;
    logic [15:0] i_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic [11:0] i_fetch_index = '0;
    logic        o_valid;
    logic [2:0]  o_op;
    logic [23:0] o_flash_address;
    logic [12:0] o_byte_count;
    logic [7:0]  o_out_byte;
    logic        o_last;

    write_plan_predictor planner = new();
    int burst_left = 0;
    int quiet_cycles = 0;
    int writes_done = 0;
    int transfers = 0;

    flash_sector_write_planner dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            planner.check_result(o_op, o_flash_address, o_byte_count, o_out_byte, o_last);
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("flash_sector_write_planner_tb: errors");
            $finish;
        end
    end

    task automatic send(t_cmd cmd, logic [23:0] addr, logic [15:0] len,
                        logic [7:0] data, logic [11:0] idx);
        if (burst_left == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 3000)
                                                      : $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1;
        i_cmd <= cmd;
        i_start_address <= addr;
        i_length <= len;
        i_data_byte <= data;
        i_fetch_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        planner.note_transfer(cmd, addr, len, data, idx);
        transfers++;
    endtask

    task automatic maybe_fetch();
        logic [11:0] idx;
        idx = 12'($urandom);
        if (planner.written[idx]) send(CMD_FETCH, 24'($urandom), 16'($urandom), 8'($urandom), idx);
    endtask

    // Old-byte modes: 0 all erased, 1 random content, 2 erased but one random byte.
    task automatic write_run(logic [23:0] addr, logic [15:0] len, bit noisy);
        int left;
        int off;
        int n;
        int mode;
        int odd_pos;
        logic [7:0] b;
        left = len;
        send(CMD_START, addr, len, 8'($urandom), 12'($urandom));
        while (left > 0) begin
            off = addr % SECTOR;
            n = (left < SECTOR - off) ? left : SECTOR - off;
            mode = $urandom_range(0, 2);
            odd_pos = $urandom_range(0, SECTOR - 1);
            for (int i = 0; i < SECTOR; i++) begin
                if (noisy && $urandom_range(0, 199) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send(CMD_NEW, '0, '0, 8'($urandom), '0);
                        1: send(CMD_START, 24'($urandom), 16'($urandom), '0, '0);
                        default: maybe_fetch();
                    endcase
                end
                b = (mode == 1 || (mode == 2 && i == odd_pos)) ? 8'($urandom) : ERASED_BYTE;
                send(CMD_OLD, 24'($urandom), 16'($urandom), b, 12'($urandom));
            end
            for (int i = 0; i < n; i++) begin
                if (noisy && $urandom_range(0, 49) == 0) begin
                    if ($urandom_range(0, 1)) send(CMD_OLD, '0, '0, 8'($urandom), '0);
                    else maybe_fetch();
                end
                send(CMD_NEW, 24'($urandom), 16'($urandom), 8'($urandom), 12'($urandom));
            end
            addr = addr + 24'(n);
            left -= n;
        end
        writes_done++;
    endtask

    initial begin
        logic [23:0] a;
        logic [15:0] l;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(CMD_OLD, '0, '0, 8'h00, '0);
        send(CMD_NEW, '0, '0, 8'hFF, '0);
        send(CMD_START, 24'hABCDEF, 16'h0000, '0, '0);
        write_run(24'hFFFFFF, 16'd1, 0);
        send(CMD_FETCH, '0, '0, '0, 12'hFFF);
        send(CMD_FETCH, '0, '0, '0, 12'h000);
        write_run(24'hFFFFFF, 16'd2, 0);
        write_run(24'h000F80, 16'd300, 1);
        write_run(24'h000000, 16'hFFFF, 0);
        send(CMD_FETCH, 24'hFFFFFF, 16'hFFFF, 8'hFF, 12'hFFF);

        // Hold off until the block has drained every planned operation.
        start <= 0;
        while (planner.planned_ops.size() != 0) @(posedge i_clk);

        for (int k = 0; k < 8; k++) begin
            a = 24'($urandom);
            if ($urandom_range(0, 2) == 0) a[11:0] = 12'(SECTOR - $urandom_range(1, 64));
            l = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 9000))
                                            : 16'($urandom_range(1, 600));
            write_run(a, l, 1);
            repeat ($urandom_range(0, 3)) maybe_fetch();
            if ($urandom_range(0, 4) == 0) send(CMD_START, 24'($urandom), '0, '0, '0);
            if ($urandom_range(0, 4) == 0) send(CMD_OLD, '0, '0, 8'($urandom), '0);
        end

        start <= 0;
        while (planner.planned_ops.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d writes over %0d transfers, %0d results checked.",
                 writes_done, transfers, planner.checked);
        if (planner.mismatches == 0 && planner.planned_ops.size() == 0)
            $display("flash_sector_write_planner_tb: clean");
        else
            $display("flash_sector_write_planner_tb: errors");
        $finish;
    end
endmodule
